>>> rtl/button_press_classifier_defines.svh
// ----------------------------------------------------------------------------
// Button press classifier assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("button_press_classifier: check failed");

// next-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("button_press_classifier: check failed");

`endif

>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Button press classifier package
// Widths, constants, codes and shared types of the classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIME_BITS      = 32;
    localparam int NOW_BITS       = 32;
    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COUNT_BITS     = 4;
    localparam int EVENT_BITS     = 3;
    localparam int BEEP_BITS      = 10;

    typedef logic [TIME_BITS-1:0]      ms_t;
    typedef logic [NOW_BITS-1:0]       now_t;
    typedef logic [CFG_BITS-1:0]       cfg_word_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [BEEP_BITS-1:0]      beep_t;

    localparam count_t CLICK_CLAMP = count_t'(10);
    localparam count_t CLICK_MAX   = count_t'(15);

    localparam beep_t BEEP_NONE  = beep_t'(0);
    localparam beep_t BEEP_SHORT = beep_t'(150);
    localparam beep_t BEEP_LONG  = beep_t'(300);
    localparam beep_t BEEP_HOLD  = beep_t'(600);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_VERY_LONG  = 2'd2,
        REG_WINDOW     = 2'd3
    } reg_index_t;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE      = 3'd0,
        EV_SINGLE    = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_TRIPLE    = 3'd3,
        EV_FIVE      = 3'd4,
        EV_LONG      = 3'd5,
        EV_VERY_LONG = 3'd6
    } event_t;

    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_POLL = 1'b1
    } command_t;

    localparam cfg_word_t DEBOUNCE_RESET   = cfg_word_t'(50);
    localparam cfg_word_t LONG_PRESS_RESET = cfg_word_t'(1000);
    localparam cfg_word_t VERY_LONG_RESET  = cfg_word_t'(4000);
    localparam cfg_word_t WINDOW_RESET     = cfg_word_t'(400);

    typedef struct packed {
        cfg_word_t debounce_ms;
        cfg_word_t long_press_ms;
        cfg_word_t very_long_press_ms;
        cfg_word_t click_window_ms;
    } bpc_cfg_t;

    typedef struct packed {
        command_t command;
        logic     pin_level;
        ms_t      now_ms;
    } bpc_item_t;

    typedef struct packed {
        event_t event_code;
        beep_t  beep_ms;
    } bpc_result_t;

    typedef struct packed {
        logic   edge_seen;
        ms_t    last_edge_time;
        logic   pressed_flag;
        ms_t    press_start_time;
        count_t click_count;
        logic   window_armed;
        ms_t    last_release_time;
        logic   hold_active;
        logic   hold_beep_done;
    } bpc_state_t;

endpackage

>>> rtl/bpc_classify.sv
// ----------------------------------------------------------------------------
// Button press classifier decision logic
// Computes the result and the next tracking state for one edge or poll.
// ----------------------------------------------------------------------------
module bpc_classify (
    input  bpc_pkg::bpc_cfg_t    cfg,
    input  bpc_pkg::bpc_state_t  st,
    input  bpc_pkg::bpc_item_t   item,
    output bpc_pkg::bpc_state_t  st_next,
    output bpc_pkg::bpc_result_t result
);
    import bpc_pkg::*;

    ms_t    since_edge;
    ms_t    since_press;
    ms_t    since_release;
    logic   bounced;
    logic   window_done;
    logic   hold_due;
    count_t clicks;

    assign since_edge    = item.now_ms - st.last_edge_time;
    assign since_press   = item.now_ms - st.press_start_time;
    assign since_release = item.now_ms - st.last_release_time;

    assign bounced     = st.edge_seen && (since_edge < ms_t'(cfg.debounce_ms));
    assign window_done = st.window_armed && (since_release >= ms_t'(cfg.click_window_ms));
    assign hold_due    = st.hold_active && !st.hold_beep_done
                         && (since_press > ms_t'(cfg.very_long_press_ms));
    assign clicks      = (st.click_count > CLICK_CLAMP) ? CLICK_CLAMP : st.click_count;

    always_comb begin
        st_next           = st;
        result.event_code = EV_NONE;
        result.beep_ms    = BEEP_NONE;
        unique case (item.command)
            CMD_EDGE: begin
                if (!bounced) begin
                    st_next.edge_seen      = 1'b1;
                    st_next.last_edge_time = item.now_ms;
                    if (!item.pin_level) begin
                        st_next.press_start_time = item.now_ms;
                        st_next.pressed_flag     = 1'b1;
                        st_next.window_armed     = 1'b0;
                        st_next.hold_active      = 1'b1;
                        st_next.hold_beep_done   = 1'b0;
                    end else begin
                        st_next.hold_active  = 1'b0;
                        st_next.pressed_flag = 1'b0;
                        if (st.pressed_flag) begin
                            if (since_press >= ms_t'(cfg.very_long_press_ms)) begin
                                st_next.click_count = '0;
                                result.event_code   = EV_VERY_LONG;
                            end else if (since_press >= ms_t'(cfg.long_press_ms)) begin
                                st_next.click_count = '0;
                                result.event_code   = EV_LONG;
                                result.beep_ms      = BEEP_LONG;
                            end else begin
                                if (st.click_count < CLICK_MAX) begin
                                    st_next.click_count = st.click_count + count_t'(1);
                                end
                                st_next.last_release_time = item.now_ms;
                                st_next.window_armed      = 1'b1;
                                result.beep_ms            = BEEP_SHORT;
                            end
                        end
                    end
                end
            end
            CMD_POLL: begin
                if (window_done) begin
                    st_next.window_armed = 1'b0;
                    st_next.click_count  = '0;
                    unique case (clicks)
                        count_t'(1): result.event_code = EV_SINGLE;
                        count_t'(2): result.event_code = EV_DOUBLE;
                        count_t'(3): result.event_code = EV_TRIPLE;
                        count_t'(5): result.event_code = EV_FIVE;
                        default:     result.event_code = EV_NONE;
                    endcase
                end else if (hold_due) begin
                    st_next.hold_beep_done = 1'b1;
                    result.beep_ms         = BEEP_HOLD;
                end
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule

>>> rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// Button press classifier
// Classifies presses of one active-low button into click and hold events.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per pin edge (s_command = 0, s_pin_level is the
// new level, 1 released) or time poll (s_command = 1), stamped with s_now_ms.
// Result channel m_*: exactly one item per input item, in order, carrying
// m_event_code (0 none, 1..3 clicks, 4 five clicks, 5 long, 6 very long) and
// m_beep_ms (0, 150, 300 or 600).
// Configuration channel cfg_*: index 0 debounce, 1 long press, 2 very long
// press, 3 click window, all in ms; cfg_ready is always high. Write only while
// no item is in flight.
// Path: one input register feeds the decision logic, which updates the
// tracking state and loads the result register in the same cycle.
// Throughput: one item per cycle while the receiver takes results.
// Reset: tracking state and configuration registers return to their defaults,
// both stages empty. When the receiver stalls, the result holds, the input
// register fills, and s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "button_press_classifier_defines.svh"

module button_press_classifier (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic                   s_pin_level,
    input  bpc_pkg::now_t          s_now_ms,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_event_code,
    output bpc_pkg::beep_t         m_beep_ms,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  bpc_pkg::cfg_index_t    cfg_index,
    input  bpc_pkg::cfg_word_t     cfg_data
);
    import bpc_pkg::*;

    bpc_cfg_t    cfg_reg;
    bpc_state_t  st_reg;
    bpc_state_t  st_next;
    bpc_item_t   in_reg;
    logic        in_valid_reg;
    bpc_result_t res_next;
    bpc_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        s_take;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms        <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms      <= LONG_PRESS_RESET;
            cfg_reg.very_long_press_ms <= VERY_LONG_RESET;
            cfg_reg.click_window_ms    <= WINDOW_RESET;
        end else if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_DEBOUNCE:   cfg_reg.debounce_ms        <= cfg_data;
                REG_LONG_PRESS: cfg_reg.long_press_ms      <= cfg_data;
                REG_VERY_LONG:  cfg_reg.very_long_press_ms <= cfg_data;
                REG_WINDOW:     cfg_reg.click_window_ms    <= cfg_data;
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg.command   <= command_t'(s_command);
            in_reg.pin_level <= s_pin_level;
            in_reg.now_ms    <= ms_t'(s_now_ms);
        end
    end

    bpc_classify u_classify (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (in_reg),
        .st_next (st_next),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{hold_beep_done: 1'b1, default: '0};
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_code = out_reg.event_code;
    assign m_beep_ms    = out_reg.beep_ms;

    `BPC_ASSERT_NOW(a_hold_beep_alone, aclk, aresetn,
        m_valid && (m_beep_ms == BEEP_HOLD), m_event_code == EV_NONE)
    `BPC_ASSERT_NEXT(a_hold_beep_once, aclk, aresetn,
        advance && (res_next.beep_ms == BEEP_HOLD), st_reg.hold_beep_done)
    `BPC_ASSERT_NEXT(a_burst_closed, aclk, aresetn,
        advance && (in_reg.command == CMD_POLL) && (res_next.event_code != EV_NONE),
        !st_reg.window_armed && (st_reg.click_count == '0))
    `BPC_ASSERT_NEXT(a_result_follows, aclk, aresetn,
        advance, m_valid)

endmodule

>>> tb/tb_button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives pin edges and time polls through the input channel and checks every
// result against a behavioral predictor, or the table where a row is typed.
// It starts with a table of directed items and follows with random click
// bursts, holds and noise under several register settings, extremes included.
// Both channels idle at random; the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_button_press_classifier;
    import bpc_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int RX_STALL_CYCLES = 300;
    localparam int RX_STALL_AT     = 600;
    localparam int PHASE_ITEMS     = 320;
    localparam int NUM_PHASES      = 6;
    localparam int DRAIN_CYCLES    = 10;
    localparam int NUM_DIR         = 24;
    localparam int MAX_REPORTS     = 50;

    typedef struct packed {
        command_t cmd;
        logic     lvl;
        now_t     t;
        logic     typed;
        event_t   ev;
        beep_t    beep;
    } dir_row_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_command   = 1'b0;
    logic       s_pin_level = 1'b1;
    now_t       s_now_ms    = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [2:0] m_event_code;
    beep_t      m_beep_ms;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index   = '0;
    cfg_word_t  cfg_data    = '0;

    bpc_state_t  btn;
    bpc_cfg_t    cfg_shadow;
    bpc_result_t expected_q [$];
    dir_row_t    dir_rows [NUM_DIR];
    now_t        clock_ms;

    int items_sent;
    int results_seen;
    int mismatches;
    int idle_cycles;
    int settings_done;
    int hold_beeps;
    int tx_quiet;
    int event_hits [8];

    button_press_classifier DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_pin_level  (s_pin_level),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_beep_ms    (m_beep_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bpc_result_t predict_press(bpc_item_t it);
        bpc_result_t r;
        ms_t         span;
        count_t      clicks;
        r.event_code = EV_NONE;
        r.beep_ms    = BEEP_NONE;
        if (it.command == CMD_POLL) begin
            span = it.now_ms - btn.last_release_time;
            if (btn.window_armed && span >= ms_t'(cfg_shadow.click_window_ms)) begin
                clicks = (btn.click_count > CLICK_CLAMP) ? CLICK_CLAMP : btn.click_count;
                btn.window_armed = 1'b0;
                btn.click_count  = '0;
                case (clicks)
                    count_t'(1): r.event_code = EV_SINGLE;
                    count_t'(2): r.event_code = EV_DOUBLE;
                    count_t'(3): r.event_code = EV_TRIPLE;
                    count_t'(5): r.event_code = EV_FIVE;
                    default:     r.event_code = EV_NONE;
                endcase
            end else begin
                span = it.now_ms - btn.press_start_time;
                if (btn.hold_active && !btn.hold_beep_done &&
                    span > ms_t'(cfg_shadow.very_long_press_ms)) begin
                    btn.hold_beep_done = 1'b1;
                    r.beep_ms = BEEP_HOLD;
                end
            end
        end else begin
            span = it.now_ms - btn.last_edge_time;
            if (!(btn.edge_seen && span < ms_t'(cfg_shadow.debounce_ms))) begin
                btn.edge_seen      = 1'b1;
                btn.last_edge_time = it.now_ms;
                if (!it.pin_level) begin
                    btn.press_start_time = it.now_ms;
                    btn.pressed_flag     = 1'b1;
                    btn.window_armed     = 1'b0;
                    btn.hold_active      = 1'b1;
                    btn.hold_beep_done   = 1'b0;
                end else begin
                    btn.hold_active = 1'b0;
                    if (btn.pressed_flag) begin
                        span = it.now_ms - btn.press_start_time;
                        if (span >= ms_t'(cfg_shadow.very_long_press_ms)) begin
                            btn.click_count = '0;
                            r.event_code    = EV_VERY_LONG;
                        end else if (span >= ms_t'(cfg_shadow.long_press_ms)) begin
                            btn.click_count = '0;
                            r.event_code    = EV_LONG;
                            r.beep_ms       = BEEP_LONG;
                        end else begin
                            if (btn.click_count < CLICK_MAX)
                                btn.click_count = btn.click_count + count_t'(1);
                            btn.last_release_time = it.now_ms;
                            btn.window_armed      = 1'b1;
                            r.beep_ms             = BEEP_SHORT;
                        end
                    end
                    btn.pressed_flag = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // press length that stays under the long threshold where debounce allows
    function automatic int short_dur();
        int lo;
        int hi;
        lo = cfg_shadow.debounce_ms;
        hi = int'(cfg_shadow.long_press_ms) - 1;
        if (hi < lo)
            return lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int near_mark(int th);
        case ($urandom_range(0, 4))
            0:       return (th > 0) ? th - 1 : 0;
            1:       return th;
            2:       return th + 1;
            3:       return $urandom_range(th, 0);
            default: return th + $urandom_range(1, 300);
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_item(command_t cmd, logic lvl, now_t t, logic typed,
                             bpc_result_t typed_res);
        int          gap;
        bpc_item_t   it;
        bpc_result_t want;
        if (tx_quiet > 0) begin
            tx_quiet--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0)
                tx_quiet = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_pin_level <= lvl;
        s_now_ms    <= t;
        do @(posedge aclk); while (!s_ready);
        it.command   = cmd;
        it.pin_level = lvl;
        it.now_ms    = t;
        want = predict_press(it);
        expected_q.push_back(typed ? typed_res : want);
        items_sent++;
    endtask

    task automatic send_edge(logic lvl, now_t t);
        send_item(CMD_EDGE, lvl, t, 1'b0, '0);
    endtask

    task automatic send_poll(now_t t);
        send_item(CMD_POLL, logic'($urandom_range(0, 1)), t, 1'b0, '0);
    endtask

    task automatic write_regs(int d, int l, int v, int w);
        reg_index_t ids [4];
        cfg_word_t  vals [4];
        ids  = '{REG_DEBOUNCE, REG_LONG_PRESS, REG_VERY_LONG, REG_WINDOW};
        vals = '{cfg_word_t'(d), cfg_word_t'(l), cfg_word_t'(v), cfg_word_t'(w)};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= ids[k];
            cfg_data  <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
            case (ids[k])
                REG_DEBOUNCE:   cfg_shadow.debounce_ms        = vals[k];
                REG_LONG_PRESS: cfg_shadow.long_press_ms      = vals[k];
                REG_VERY_LONG:  cfg_shadow.very_long_press_ms = vals[k];
                REG_WINDOW:     cfg_shadow.click_window_ms    = vals[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic run_sequence();
        int   kind;
        int   n;
        int   k;
        int   dur;
        int   off;
        int   step;
        int   d;
        int   w;
        int   lp;
        int   vl;
        now_t press_at;
        d    = cfg_shadow.debounce_ms;
        w    = cfg_shadow.click_window_ms;
        lp   = cfg_shadow.long_press_ms;
        vl   = cfg_shadow.very_long_press_ms;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // click burst, closed by polls most of the time
            k = $urandom_range(0, 19);
            n = (k < 15) ? $urandom_range(1, 5) :
                (k < 19) ? $urandom_range(6, 11) : $urandom_range(14, 17);
            for (int i = 0; i < n; i++) begin
                clock_ms += d + $urandom_range(0, 200);
                send_edge(1'b0, clock_ms);
                if (d > 0 && $urandom_range(0, 5) == 0)
                    send_edge(logic'($urandom_range(0, 1)), clock_ms + $urandom_range(d - 1, 0));
                clock_ms += short_dur();
                send_edge(1'b1, clock_ms);
                if (w > 1 && $urandom_range(0, 3) == 0)
                    send_poll(clock_ms + $urandom_range(w - 1, 0));
            end
            if ($urandom_range(0, 3) != 0) begin
                if (w > 0)
                    send_poll(clock_ms + w - 1);
                clock_ms += w + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 100) : 0);
                send_poll(clock_ms);
            end
        end else if (kind < 70) begin
            // hold, with polls around the very long mark
            clock_ms += d + $urandom_range(0, 300);
            press_at = clock_ms;
            send_edge(1'b0, press_at);
            case ($urandom_range(0, 4))
                0:       dur = near_mark(lp);
                1, 2:    dur = near_mark(vl);
                3:       dur = short_dur();
                default: dur = vl + $urandom_range(1, 3000);
            endcase
            step = (vl > 3) ? vl / 3 : 1;
            off  = 0;
            n    = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) begin
                off += $urandom_range(step, 1);
                if (off < dur)
                    send_poll(press_at + off);
            end
            if (vl + 1 < dur && $urandom_range(0, 3) != 0) begin
                send_poll(press_at + vl);
                send_poll(press_at + vl + 1);
                if ($urandom_range(0, 1) == 0)
                    send_poll(press_at + vl + 1 + $urandom_range(0, 50));
            end
            clock_ms = press_at + dur;
            send_edge(1'b1, clock_ms);
        end else if (kind < 85) begin
            // noise: bounces, time jumps, repeated levels
            case ($urandom_range(0, 3))
                0: begin
                    clock_ms += $urandom_range(0, d + 20);
                    send_edge(logic'($urandom_range(0, 1)), clock_ms);
                end
                1: begin
                    clock_ms = $urandom();
                    if ($urandom_range(0, 1) == 0)
                        send_edge(logic'($urandom_range(0, 1)), clock_ms);
                    else
                        send_poll(clock_ms);
                end
                2: begin
                    clock_ms += $urandom_range(0, 70000);
                    send_poll(clock_ms);
                end
                default: begin
                    k = $urandom_range(0, 1);
                    clock_ms += d + $urandom_range(0, 500);
                    send_edge(logic'(k), clock_ms);
                    clock_ms += d + $urandom_range(0, 500);
                    send_edge(logic'(k), clock_ms);
                end
            endcase
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                clock_ms += $urandom_range(0, w + 50);
                send_poll(clock_ms);
            end
        end
    endtask

    // idle and stall the result channel
    initial begin : result_ready_gen
        int  hold;
        int  rx_quiet;
        bit  rx_stall_done;
        rx_quiet      = 0;
        rx_stall_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!rx_stall_done && results_seen >= RX_STALL_AT) begin
                rx_stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (RX_STALL_CYCLES - 1) @(posedge aclk);
            end else if (rx_quiet > 0) begin
                rx_quiet--;
                m_ready <= 1'b1;
            end else begin
                hold = pick_gap();
                if (hold == 0) begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        rx_quiet = $urandom_range(20, 100);
                end else begin
                    m_ready <= 1'b0;
                    repeat (hold - 1) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        bpc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            event_hits[m_event_code]++;
            if (m_beep_ms == BEEP_HOLD)
                hold_beeps++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result event_code", m_event_code, -1);
            end else begin
                want = expected_q.pop_front();
                if (m_event_code !== want.event_code)
                    report_mismatch("event_code", m_event_code, want.event_code);
                if (m_beep_ms !== want.beep_ms)
                    report_mismatch("beep_ms", m_beep_ms, want.beep_ms);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int d;
        int l;
        int v;
        int w;
        cfg_shadow.debounce_ms        = DEBOUNCE_RESET;
        cfg_shadow.long_press_ms      = LONG_PRESS_RESET;
        cfg_shadow.very_long_press_ms = VERY_LONG_RESET;
        cfg_shadow.click_window_ms    = WINDOW_RESET;
        btn                = '0;
        btn.hold_beep_done = 1'b1;
        clock_ms           = '0;
        tx_quiet           = 0;

        dir_rows = '{
            '{CMD_POLL, 1'b1, 32'd0,          1'b1, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'd10,         1'b1, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'd20,         1'b1, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'd100,        1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'd200,        1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_POLL, 1'b0, 32'd4200,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_POLL, 1'b1, 32'd4201,       1'b1, EV_NONE,      BEEP_HOLD},
            '{CMD_POLL, 1'b0, 32'd5000,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'd5000,       1'b1, EV_VERY_LONG, BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'd6000,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'd7000,       1'b1, EV_LONG,      BEEP_LONG},
            '{CMD_EDGE, 1'b0, 32'd8000,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'd8100,       1'b1, EV_NONE,      BEEP_SHORT},
            '{CMD_POLL, 1'b1, 32'd8499,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_POLL, 1'b0, 32'd8500,       1'b1, EV_SINGLE,    BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'd9000,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'd9100,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'd9200,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'd9300,       1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_POLL, 1'b1, 32'd9700,       1'b1, EV_DOUBLE,    BEEP_NONE},
            '{CMD_EDGE, 1'b0, 32'hFFFF_FFFF,  1'b1, EV_NONE,      BEEP_NONE},
            '{CMD_EDGE, 1'b1, 32'h0000_00FF,  1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_POLL, 1'b0, 32'h0000_01FF,  1'b0, EV_NONE,      BEEP_NONE},
            '{CMD_POLL, 1'b1, 32'h0000_0290,  1'b1, EV_SINGLE,    BEEP_NONE}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIR; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].lvl, dir_rows[i].t, dir_rows[i].typed,
                      '{dir_rows[i].ev, dir_rows[i].beep});
        clock_ms = 32'h0000_0290;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // drain before touching the registers
            s_valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge aclk);
            case (p)
                0: write_regs(DEBOUNCE_RESET, LONG_PRESS_RESET, VERY_LONG_RESET, WINDOW_RESET);
                1: write_regs(0, 65535, 65535, 0);
                2: write_regs(65535, 0, 0, 65535);
                3: begin
                    d = $urandom_range(0, 60);
                    l = $urandom_range(1500, d + 1);
                    v = $urandom_range(5000, l);
                    w = $urandom_range(600, 1);
                    write_regs(d, l, v, w);
                end
                4: begin
                    l = $urandom_range(1500, 50);
                    v = $urandom_range(l, 0);
                    w = $urandom_range(300, 0);
                    write_regs(0, l, v, w);
                end
                default: write_regs($urandom_range(65535, 0), $urandom_range(65535, 0),
                                    $urandom_range(65535, 0), $urandom_range(65535, 0));
            endcase
            while (items_sent < NUM_DIR + (p + 1) * PHASE_ITEMS)
                run_sequence();
        end

        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch("results still outstanding", 0, expected_q.size());

        $display("Sent %0d items, checked %0d results under %0d register settings",
                 items_sent, results_seen, settings_done);
        $display("Events: single %0d, double %0d, triple %0d, five %0d, long %0d, %s %0d, %s %0d",
                 event_hits[EV_SINGLE], event_hits[EV_DOUBLE], event_hits[EV_TRIPLE],
                 event_hits[EV_FIVE], event_hits[EV_LONG], "very long",
                 event_hits[EV_VERY_LONG], "hold beeps", hold_beeps);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_classify.sv
rtl/button_press_classifier.sv
tb/tb_button_press_classifier.sv
